// ----- hw/rtl/fpws_pkg.sv -----
`timescale 1ns / 1ps

package fpws_pkg;

    // Default sizing
    localparam int PATTERNS_DEF        = 64;
    localparam int MAX_PATTERN_LEN_DEF = 10;
    localparam int LENGTH_BITS_DEF     = 16;

    // Fixed field widths
    localparam int LETTER_W   = 5;
    localparam int PLETTERS_W = 50;
    localparam int PLEN_W     = 4;
    localparam int OUT_LEN_W  = 16;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_LOAD     = 2'd0,
        KIND_LETTER   = 2'd1,
        KIND_NEW_WORD = 2'd2,
        KIND_RESERVED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [LETTER_W-1:0]     letter;
        logic [PLETTERS_W-1:0]   pattern_letters;
        logic [PLEN_W-1:0]       pattern_length;
    } in_item_t;

    typedef struct packed {
        logic [OUT_LEN_W-1:0]    longest_valid;
        logic [OUT_LEN_W-1:0]    window_length;
    } out_item_t;

endpackage

// ----- hw/rtl/fpws_store.sv -----
`timescale 1ns / 1ps

// Pattern table with one registered read port and the suffix comparator
module fpws_store #(
    parameter int PATTERNS        = fpws_pkg::PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = fpws_pkg::MAX_PATTERN_LEN_DEF,
    localparam int ADDR_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1,
    localparam int STORE_W = fpws_pkg::LETTER_W * MAX_PATTERN_LEN
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [STORE_W-1:0]            wr_letters,
    input  logic [fpws_pkg::PLEN_W-1:0]   wr_length,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    input  logic [STORE_W-1:0]            hist,
    input  logic [fpws_pkg::PLEN_W-1:0]   limit,
    output logic                          hit,
    output logic [fpws_pkg::PLEN_W-1:0]   hit_len
);

    localparam int LW   = fpws_pkg::LETTER_W;
    localparam int HI_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    logic [STORE_W-1:0]          mem_letters [PATTERNS];
    logic [fpws_pkg::PLEN_W-1:0] mem_length  [PATTERNS];
    logic [STORE_W-1:0]          rd_letters_reg;
    logic [fpws_pkg::PLEN_W-1:0] rd_length_reg;
    logic [LW-1:0]               hist_arr [MAX_PATTERN_LEN];
    logic                        letters_ok;
    logic [fpws_pkg::PLEN_W-1:0] idx;

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_letters[wr_addr] <= wr_letters;
            mem_length[wr_addr]  <= wr_length;
        end
        if (rd_en)
        begin
            rd_letters_reg <= mem_letters[rd_addr];
            rd_length_reg  <= mem_length[rd_addr];
        end
    end

    // History slots, newest in slot 0
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN_LEN; j++)
        begin
            hist_arr[j] = hist[j*LW +: LW];
        end
    end

    // Pattern letter k faces the letter len-1-k places back
    always_comb
    begin
        letters_ok = 1'b1;
        idx        = '0;
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            if (fpws_pkg::PLEN_W'(k) < rd_length_reg)
            begin
                idx = rd_length_reg - fpws_pkg::PLEN_W'(k) - fpws_pkg::PLEN_W'(1);
                if (rd_letters_reg[k*LW +: LW] != hist_arr[idx[HI_W-1:0]])
                begin
                    letters_ok = 1'b0;
                end
            end
        end
    end

    assign hit     = letters_ok && (rd_length_reg != '0) && (rd_length_reg <= limit);
    assign hit_len = rd_length_reg;

endmodule

// ----- hw/rtl/forbidden_pattern_window_scanner_unit.sv -----
`timescale 1ns / 1ps

// Channel   Signals                       Payload
// -------   ---------------------------   ---------------------------------------
// in        in_valid / in_ready            in_data  (kind, letter, pattern fields)
// out       out_valid / out_ready          out_data (longest_valid, window_length)
//
// A letter item sweeps the N loaded patterns through the single table read port,
// one entry per cycle, then passes ST_DRAIN and ST_FINISH; with an empty table
// it goes straight to ST_FINISH, which waits until the result register is free.
// Loads, new words and the reserved kind leave the sequencer idle and give no result.
// Reset is asynchronous and clears control state; the table holds no reset.
// in_ready is high whenever the sequencer is idle, even while a result waits.
module forbidden_pattern_window_scanner_unit #(
    parameter int PATTERNS        = fpws_pkg::PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = fpws_pkg::MAX_PATTERN_LEN_DEF,
    parameter int LENGTH_BITS     = fpws_pkg::LENGTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fpws_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fpws_pkg::out_item_t out_data
);

    localparam int LW      = fpws_pkg::LETTER_W;
    localparam int PW      = fpws_pkg::PLEN_W;
    localparam int ADDR_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int CNT_W   = $clog2(PATTERNS + 1);
    localparam int STORE_W = LW * MAX_PATTERN_LEN;
    localparam int WIDE_W  = (fpws_pkg::PLETTERS_W > STORE_W) ? fpws_pkg::PLETTERS_W : STORE_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        loaded_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic                    cmp_en_reg;
    logic                    found_reg;
    logic [PW-1:0]           found_len_reg;
    logic [PW-1:0]           limit_reg, limit_next;
    logic [LENGTH_BITS-1:0]  cw_reg, cw_next;
    logic [LENGTH_BITS-1:0]  bw_reg, bw_next;
    logic [STORE_W-1:0]      hist_reg;
    logic                    out_valid_reg;
    fpws_pkg::out_item_t     out_data_reg;

    logic                    in_acc;
    logic                    load_ok;
    logic                    scan_last;
    logic                    out_free;
    logic [WIDE_W-1:0]       pat_wide;
    logic [STORE_W-1:0]      pat_masked;
    logic                    hit;
    logic [PW-1:0]           hit_len;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == loaded_reg);

    // Load acceptance and letter masking
    assign load_ok = (in_data.kind == fpws_pkg::KIND_LOAD)
                  && (loaded_reg < CNT_W'(PATTERNS))
                  && (in_data.pattern_length != '0)
                  && (in_data.pattern_length <= PW'(MAX_PATTERN_LEN));
    assign pat_wide = WIDE_W'(in_data.pattern_letters);

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            pat_masked[k*LW +: LW] = (PW'(k) < in_data.pattern_length)
                                   ? pat_wide[k*LW +: LW] : '0;
        end
    end

    // Search limit: window plus the new letter, capped at the maximum pattern length
    assign limit_next = (cw_reg < LENGTH_BITS'(MAX_PATTERN_LEN - 1))
                      ? PW'(cw_reg + LENGTH_BITS'(1)) : PW'(MAX_PATTERN_LEN);

    // Window update at the end of the sweep
    always_comb
    begin
        if (found_reg)
        begin
            cw_next = LENGTH_BITS'(found_len_reg - PW'(1));
        end
        else if (cw_reg != '1)
        begin
            cw_next = cw_reg + LENGTH_BITS'(1);
        end
        else
        begin
            cw_next = cw_reg;
        end
        bw_next = (cw_next > bw_reg) ? cw_next : bw_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.kind == fpws_pkg::KIND_LETTER))
                begin
                    state_next = (loaded_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= '0;
            idx_reg       <= '0;
            cmp_en_reg    <= 1'b0;
            found_reg     <= 1'b0;
            found_len_reg <= '0;
            limit_reg     <= '0;
            cw_reg        <= '0;
            bw_reg        <= '0;
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmp_en_reg <= (state_reg == ST_SCAN);

            if (in_acc)
            begin
                unique case (in_data.kind)
                    fpws_pkg::KIND_LOAD:
                    begin
                        if (load_ok)
                        begin
                            loaded_reg <= loaded_reg + CNT_W'(1);
                        end
                    end
                    fpws_pkg::KIND_LETTER:
                    begin
                        hist_reg      <= {hist_reg[STORE_W-LW-1:0], in_data.letter};
                        limit_reg     <= limit_next;
                        found_reg     <= 1'b0;
                        found_len_reg <= '0;
                        idx_reg       <= '0;
                    end
                    fpws_pkg::KIND_NEW_WORD:
                    begin
                        hist_reg <= '0;
                        cw_reg   <= '0;
                        bw_reg   <= '0;
                    end
                    fpws_pkg::KIND_RESERVED:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end

            // Keep the shortest matching pattern
            if (cmp_en_reg && hit && (!found_reg || (hit_len < found_len_reg)))
            begin
                found_reg     <= 1'b1;
                found_len_reg <= hit_len;
            end

            if ((state_reg == ST_FINISH) && out_free)
            begin
                cw_reg        <= cw_next;
                bw_reg        <= bw_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_data_reg.longest_valid <= fpws_pkg::OUT_LEN_W'(bw_next);
            out_data_reg.window_length <= fpws_pkg::OUT_LEN_W'(cw_next);
        end
    end

    fpws_store #(
        .PATTERNS        (PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_store (
        .clk        (clk),
        .wr_en      (in_acc && load_ok),
        .wr_addr    (loaded_reg[ADDR_W-1:0]),
        .wr_letters (pat_masked),
        .wr_length  (in_data.pattern_length),
        .rd_en      (state_reg == ST_SCAN),
        .rd_addr    (idx_reg),
        .hist       (hist_reg),
        .limit      (limit_reg),
        .hit        (hit),
        .hit_len    (hit_len)
    );

    // Checks
    a_window_le_best: assert property (@(posedge clk) disable iff (!rst_n)
        cw_reg <= bw_reg)
        else $error("window exceeds longest window");

    a_found_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (found_len_reg != '0) && (found_len_reg <= limit_reg))
        else $error("matched length outside search limit");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(PATTERNS))
        else $error("pattern count overflow");

    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free) |=> out_valid_reg)
        else $error("finished letter gave no result");

    a_letter_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_data.kind == fpws_pkg::KIND_LETTER)) |=> !in_ready)
        else $error("ready during letter search");

endmodule

// ----- sim/window_scan_checker.sv -----
`timescale 1ns / 1ps

module window_scan_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  fpws_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  fpws_pkg::out_item_t out_data,
    output int unsigned         mismatches,
    output int unsigned         lengths_owed
);
    import fpws_pkg::*;

    localparam int NPAT   = PATTERNS_DEF;
    localparam int MAXLEN = MAX_PATTERN_LEN_DEF;
    localparam logic [OUT_LEN_W-1:0] LEN_TOP = '1;

    // Own copy of the scanner state; newest letter at index 0
    logic [LETTER_W-1:0]   history [MAXLEN];
    logic [PLETTERS_W-1:0] pat_codes [NPAT];
    logic [PLEN_W-1:0]     pat_len [NPAT];
    int unsigned           pat_count;
    logic [OUT_LEN_W-1:0]  window_len;
    logic [OUT_LEN_W-1:0]  best_len;

    out_item_t             lengths_q [$];
    out_item_t             owed;
    out_item_t             fresh;
    logic [PLETTERS_W-1:0] kept;
    int unsigned           fails;

    // True when a stored pattern of n letters equals the newest n letters
    function automatic bit suffix_forbidden(int n);
        bit hit;
        bit same;
        hit = 1'b0;
        for (int e = 0; e < pat_count; e++) begin
            if (pat_len[e] == n) begin
                same = 1'b1;
                for (int k = 0; k < n; k++)
                    if (pat_codes[e][LETTER_W*k +: LETTER_W] != history[n-1-k])
                        same = 1'b0;
                if (same)
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Shift a letter in and work out the new window and best lengths
    function automatic out_item_t scan_letter(logic [LETTER_W-1:0] code);
        int        reach;
        int        n;
        bit        hit;
        out_item_t lengths;
        for (int i = MAXLEN - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = code;
        // search never looks past the window or the maximum pattern length
        reach = (int'(window_len) + 1 < MAXLEN) ? int'(window_len) + 1 : MAXLEN;
        hit = 1'b0;
        n = 1;
        while (!hit && n <= reach) begin
            if (suffix_forbidden(n))
                hit = 1'b1;
            else
                n++;
        end
        if (hit)
            window_len = OUT_LEN_W'(n - 1);
        else if (window_len != LEN_TOP)
            window_len++;
        if (window_len > best_len)
            best_len = window_len;
        lengths.longest_valid = best_len;
        lengths.window_length = window_len;
        return lengths;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAXLEN; i++)
                history[i] = '0;
            pat_count  = 0;
            window_len = '0;
            best_len   = '0;
            fails      = 0;
            lengths_q.delete();
            mismatches   <= 0;
            lengths_owed <= 0;
        end
        else begin
            // result side: always belongs to an item taken earlier
            if (out_valid && out_ready) begin
                if (lengths_q.size() == 0) begin
                    $error("unexpected result: longest_valid %0d, window_length %0d",
                           out_data.longest_valid, out_data.window_length);
                    fails++;
                end
                else begin
                    owed = lengths_q.pop_front();
                    if (out_data.longest_valid !== owed.longest_valid) begin
                        $error("longest_valid: expected %0d, got %0d",
                               owed.longest_valid, out_data.longest_valid);
                        fails++;
                    end
                    if (out_data.window_length !== owed.window_length) begin
                        $error("window_length: expected %0d, got %0d",
                               owed.window_length, out_data.window_length);
                        fails++;
                    end
                end
            end

            // input side
            if (in_valid && in_ready) begin
                case (in_data.kind)
                    KIND_LOAD: begin
                        // full table or bad length: dropped
                        if (pat_count < NPAT && in_data.pattern_length >= 1
                            && in_data.pattern_length <= MAXLEN) begin
                            kept = '0;
                            for (int k = 0; k < in_data.pattern_length; k++)
                                kept[LETTER_W*k +: LETTER_W] =
                                    in_data.pattern_letters[LETTER_W*k +: LETTER_W];
                            pat_codes[pat_count] = kept;
                            pat_len[pat_count]   = in_data.pattern_length;
                            pat_count++;
                        end
                    end
                    KIND_NEW_WORD: begin
                        // table survives a new word
                        for (int i = 0; i < MAXLEN; i++)
                            history[i] = '0;
                        window_len = '0;
                        best_len   = '0;
                    end
                    KIND_LETTER: begin
                        fresh     = scan_letter(in_data.letter);
                        lengths_q = {lengths_q, fresh};
                    end
                    default: ;
                endcase
            end

            mismatches   <= fails;
            lengths_owed <= lengths_q.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import fpws_pkg::*;

    localparam int RANDOM_ITEMS = 740;
    localparam int CALM_LETTERS = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 200;
    localparam int TABLE_SLOTS  = PATTERNS_DEF;

    // Forbidden patterns used by the directed part, first letter lowest
    localparam logic [PLETTERS_W-1:0] PAT_AB  = {40'd0, 5'd1, 5'd0};
    localparam logic [PLETTERS_W-1:0] PAT_TEN =
        {5'd5, 5'd4, 5'd3, 5'd2, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    int unsigned mismatches;
    int unsigned lengths_owed;
    bit          idle_on;
    bit          long_hold;

    forbidden_pattern_window_scanner_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    window_scan_checker u_scan_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .mismatches   (mismatches),
        .lengths_owed (lengths_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #40_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= !(idle_on && $urandom_range(0, 99) < 34);
        end
    end

    // Every field random; callers overwrite the ones that matter
    function automatic in_item_t random_fill(kind_t k);
        in_item_t it;
        it.kind            = k;
        it.letter          = LETTER_W'($urandom_range(0, 31));
        it.pattern_letters = PLETTERS_W'({$urandom(), $urandom()});
        it.pattern_length  = PLEN_W'($urandom_range(0, 15));
        return it;
    endfunction

    // Offer one item, idling first at random, and return once it is taken
    task automatic offer(input in_item_t it);
        while (idle_on && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_letter(input logic [LETTER_W-1:0] code);
        in_item_t it;
        it = random_fill(KIND_LETTER);
        it.letter = code;
        offer(it);
    endtask

    // Letters past the length keep random junk
    task automatic send_load(input logic [PLETTERS_W-1:0] codes, input int n);
        in_item_t it;
        it = random_fill(KIND_LOAD);
        for (int k = 0; k < n && k < MAX_PATTERN_LEN_DEF; k++)
            it.pattern_letters[LETTER_W*k +: LETTER_W] = codes[LETTER_W*k +: LETTER_W];
        it.pattern_length = PLEN_W'(n);
        offer(it);
    endtask

    task automatic send_word();
        offer(random_fill(KIND_NEW_WORD));
    endtask

    // Sender goes quiet until every owed result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lengths_owed != 0) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        logic [PLETTERS_W-1:0] codes;
        int                    pick;
        int                    n;
        int                    counted;
        int                    loads_taken;
        bit                    paused;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        idle_on   = 1'b1;
        long_hold = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: each letter lengthens the window
        send_letter(LETTER_W'(0));
        send_letter(LETTER_W'(25));
        send_letter(LETTER_W'(31));

        // long stretch with no idling on either side
        drain();
        idle_on <= 1'b0;
        for (int i = 0; i < CALM_LETTERS; i++)
            send_letter(LETTER_W'($urandom_range(0, 31)));
        drain();
        idle_on <= 1'b1;

        // reserved kind, new word, loads with bad lengths
        offer(random_fill(KIND_RESERVED));
        send_word();
        send_load('0, 0);
        send_load('0, 11);
        send_load('0, 15);
        // duplicate short pattern and one of full length with codes above z
        send_load(PAT_AB, 2);
        send_load(PAT_AB, 2);
        send_load(PAT_TEN, 10);
        send_word();
        for (int k = 0; k < 10; k++)
            send_letter(PAT_TEN[LETTER_W*k +: LETTER_W]);
        send_letter(LETTER_W'(0));
        send_letter(LETTER_W'(1));

        // random words over a small alphabet so patterns keep hitting
        counted     = 0;
        loads_taken = 3;
        paused      = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == 400)
                long_hold <= 1'b1;
            if (counted == 600 && !paused)
            begin
                drain();
                paused = 1'b1;
            end
            // letters only while the receiver is held off
            pick = (counted >= 400 && counted < 430) ? 99 : $urandom_range(0, 99);
            if (pick < 12)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(2, 5);
                codes = '0;
                for (int k = 0; k < MAX_PATTERN_LEN_DEF; k++)
                    codes[LETTER_W*k +: LETTER_W] =
                        LETTER_W'($urandom_range(0, (n > 5) ? 31 : 7));
                send_load(codes, n);
                if (n >= 1 && n <= MAX_PATTERN_LEN_DEF && loads_taken < TABLE_SLOTS)
                begin
                    loads_taken++;
                    counted++;
                end
            end
            else if (pick < 17)
            begin
                send_word();
                counted++;
            end
            else if (pick < 19)
                offer(random_fill(KIND_RESERVED));
            else
            begin
                send_letter(($urandom_range(0, 9) < 8) ? LETTER_W'($urandom_range(0, 7))
                                                       : LETTER_W'($urandom_range(0, 31)));
                counted++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && lengths_owed == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fpws_pkg.sv
hw/rtl/fpws_store.sv
hw/rtl/forbidden_pattern_window_scanner_unit.sv
sim/window_scan_checker.sv
sim/testbench.sv
